// ===== hdl/afs_pkg.sv =====
// shared types, constants and width helpers for the animation frame sequencer
`default_nettype none

package afs_pkg;

  // fixed field widths
  localparam int MODE_W    = 3;
  localparam int ELAPSED_W = 32;
  localparam int DUR_W     = 32;
  localparam int CNT_W     = 9;
  localparam int SPEED_W   = 18;
  localparam int CFG_DW    = 32;
  localparam int CFG_AW    = 4;

  localparam int MAX_FRAMES = 256;

  localparam int DEF_TIME_BITS       = 32;
  localparam int DEF_SPEED_FRAC_BITS = 8;

  // register reset values
  localparam logic [DUR_W-1:0]   RST_DURATION = DUR_W'(1);
  localparam logic [CNT_W-1:0]   RST_FRAMES   = CNT_W'(1);
  localparam logic               RST_LOOP     = 1'b0;
  localparam logic [SPEED_W-1:0] RST_SPEED    = SPEED_W'(256);

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_DURATION = 2'd0;
  localparam logic [1:0] REG_FRAMES   = 2'd1;
  localparam logic [1:0] REG_LOOP     = 2'd2;
  localparam logic [1:0] REG_SPEED    = 2'd3;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK   = 3'd0,
    MODE_PLAY   = 3'd1,
    MODE_PAUSE  = 3'd2,
    MODE_TOGGLE = 3'd3,
    MODE_REWIND = 3'd4
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_SUM,
    ST_MOD,
    ST_MOD_END,
    ST_FMUL,
    ST_FDIV,
    ST_FDIV_END,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [DUR_W-1:0]   duration;
    logic [CNT_W-1:0]   frame_count;
    logic               loop_en;
    logic [SPEED_W-1:0] speed;
  } cfg_t;

  typedef struct packed {
    logic load_item;
    logic apply_mode;
    logic mul;
    logic sum_eval;
    logic div_step;
    logic mod_end;
    logic frame_load;
    logic frame_end;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic tick_go;
    logic sum_ge;
    logic loop_en;
    logic out_free;
  } sts_t;

  // width of accumulator plus scaled step, one carry bit on top
  function automatic int sum_width(input int time_bits, input int frac_bits);
    int sc;
    sc = ELAPSED_W + SPEED_W - frac_bits;
    return ((time_bits > sc) ? time_bits : sc) + 1;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/afs_regs.sv =====
// apb configuration registers of the animation frame sequencer
`default_nettype none

module afs_regs
  import afs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel_i,
  input  wire logic              penable_i,
  input  wire logic              pwrite_i,
  input  wire logic [CFG_AW-1:0] paddr_i,
  input  wire logic [CFG_DW-1:0] pwdata_i,
  output logic      [CFG_DW-1:0] prdata_o,
  output logic                   pready_o,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i & penable_i & pwrite_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr_i[3:2])
        REG_DURATION: cfg_d.duration    = pwdata_i[DUR_W-1:0];
        REG_FRAMES:   cfg_d.frame_count = pwdata_i[CNT_W-1:0];
        REG_LOOP:     cfg_d.loop_en     = pwdata_i[0];
        REG_SPEED:    cfg_d.speed       = pwdata_i[SPEED_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duration    <= RST_DURATION;
      cfg_q.frame_count <= RST_FRAMES;
      cfg_q.loop_en     <= RST_LOOP;
      cfg_q.speed       <= RST_SPEED;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (paddr_i[3:2])
      REG_DURATION: prdata_o = CFG_DW'(cfg_q.duration);
      REG_FRAMES:   prdata_o = CFG_DW'(cfg_q.frame_count);
      REG_LOOP:     prdata_o = CFG_DW'(cfg_q.loop_en);
      REG_SPEED:    prdata_o = CFG_DW'(cfg_q.speed);
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/afs_ctrl.sv =====
// sequencing state machine of the animation frame sequencer
`default_nettype none

module afs_ctrl
  import afs_pkg::*;
#(
  parameter int TIME_BITS       = DEF_TIME_BITS,
  parameter int SPEED_FRAC_BITS = DEF_SPEED_FRAC_BITS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  sts_t      sts_i,
  output cmd_t      cmd_o
);

  localparam int DIV_W = sum_width(TIME_BITS, SPEED_FRAC_BITS);
  localparam int CW    = $clog2(DIV_W);

  state_e          state_q, state_d;
  logic   [CW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.is_tick) begin
          state_d = sts_i.tick_go ? ST_MUL : ST_DONE;
        end else begin
          cmd_o.apply_mode = 1'b1;
          state_d          = ST_DONE;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum_eval = 1'b1;
        if (sts_i.sum_ge) begin
          if (sts_i.loop_en) begin
            cnt_d   = CW'(DIV_W - 1);
            state_d = ST_MOD;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          state_d = ST_FMUL;
        end
      end
      ST_MOD: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_MOD_END;
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      ST_MOD_END: begin
        cmd_o.mod_end = 1'b1;
        state_d       = ST_FMUL;
      end
      ST_FMUL: begin
        cmd_o.frame_load = 1'b1;
        cnt_d            = CW'(CNT_W - 1);
        state_d          = ST_FDIV;
      end
      ST_FDIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_FDIV_END;
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      ST_FDIV_END: begin
        cmd_o.frame_end = 1'b1;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/afs_dp.sv =====
// datapath of the animation frame sequencer: state, multiplier, divider, output beat
`default_nettype none

module afs_dp
  import afs_pkg::*;
#(
  parameter int TIME_BITS       = DEF_TIME_BITS,
  parameter int SPEED_FRAC_BITS = DEF_SPEED_FRAC_BITS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  cfg_t                      cfg_i,
  input  wire logic [MODE_W-1:0]    mode_i,
  input  wire logic [ELAPSED_W-1:0] elapsed_i,
  input  cmd_t                      cmd_i,
  output sts_t                      sts_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [CNT_W-1:0]     frame_index_o,
  output logic                      finished_o,
  output logic                      playing_o
);

  localparam int TB     = TIME_BITS;
  localparam int PROD_W = ELAPSED_W + SPEED_W;
  localparam int SC_W   = PROD_W - SPEED_FRAC_BITS;
  localparam int DIV_W  = sum_width(TIME_BITS, SPEED_FRAC_BITS);
  localparam int NUM_W  = TB + CNT_W;
  localparam int CMP_W  = (TB > DUR_W) ? TB : DUR_W;

  logic [MODE_W-1:0]    mode_q;
  logic [ELAPSED_W-1:0] elapsed_q;
  logic [TB-1:0]        acc_q, acc_d;
  logic [CNT_W-1:0]     frame_q, frame_d;
  logic                 play_q, play_d;
  logic [PROD_W-1:0]    prod_q;
  logic [TB-1:0]        rem_q, rem_d;
  logic [DIV_W-1:0]     dvd_q, dvd_d;
  logic [CNT_W-1:0]     quo_q, quo_d;
  logic                 out_valid_q;
  logic [CNT_W-1:0]     out_frame_q;
  logic                 out_fin_q;
  logic                 out_play_q;

  logic [CNT_W-1:0]     count_eff;
  logic [DUR_W-1:0]     dur_nz;
  logic [TB-1:0]        dur;
  logic [DIV_W-1:0]     sum;
  logic                 sum_ge;
  logic [NUM_W-1:0]     num;
  logic [TB:0]          rem_sh;
  logic                 div_ge;
  logic                 fin;

  // effective frame count and duration
  assign count_eff = (32'(cfg_i.frame_count) > 32'(MAX_FRAMES)) ?
                     CNT_W'(MAX_FRAMES) : cfg_i.frame_count;
  assign dur_nz    = (cfg_i.duration == '0) ? DUR_W'(1) : cfg_i.duration;
  assign dur       = (CMP_W'(dur_nz) > CMP_W'({TB{1'b1}})) ? {TB{1'b1}} : TB'(dur_nz);

  assign sum    = DIV_W'(acc_q) + DIV_W'(prod_q[PROD_W-1:SPEED_FRAC_BITS]);
  assign sum_ge = sum >= DIV_W'(dur);
  assign num    = NUM_W'(acc_q) * NUM_W'(count_eff);

  // restoring divide step
  assign rem_sh = {rem_q, dvd_q[DIV_W-1]};
  assign div_ge = rem_sh >= {1'b0, dur};

  assign fin = frame_q >= count_eff;

  always_comb begin
    acc_d   = acc_q;
    frame_d = frame_q;
    play_d  = play_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    quo_d   = quo_q;
    if (cmd_i.apply_mode) begin
      case (mode_q)
        MODE_PLAY:   play_d = 1'b1;
        MODE_PAUSE:  play_d = 1'b0;
        MODE_TOGGLE: play_d = ~play_q;
        MODE_REWIND: begin
          acc_d   = '0;
          frame_d = '0;
        end
        default: ;
      endcase
    end
    if (cmd_i.sum_eval) begin
      if (!sum_ge) begin
        acc_d = TB'(sum);
      end else if (cfg_i.loop_en) begin
        rem_d = '0;
        dvd_d = sum;
      end else begin
        acc_d   = (sum > DIV_W'({TB{1'b1}})) ? {TB{1'b1}} : TB'(sum);
        frame_d = count_eff;
      end
    end
    if (cmd_i.div_step) begin
      rem_d = div_ge ? TB'(rem_sh - {1'b0, dur}) : rem_sh[TB-1:0];
      dvd_d = dvd_q << 1;
      quo_d = {quo_q[CNT_W-2:0], div_ge};
    end
    if (cmd_i.mod_end) begin
      acc_d = rem_q;
    end
    if (cmd_i.frame_load) begin
      rem_d = num[NUM_W-1:CNT_W];
      dvd_d = {num[CNT_W-1:0], {(DIV_W-CNT_W){1'b0}}};
    end
    if (cmd_i.frame_end) begin
      frame_d = quo_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      frame_q     <= '0;
      play_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      frame_q <= frame_d;
      play_q  <= play_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q    <= mode_i;
      elapsed_q <= elapsed_i;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(elapsed_q) * PROD_W'(cfg_i.speed);
    end
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    if (cmd_i.out_load) begin
      out_frame_q <= frame_q;
      out_fin_q   <= fin;
      out_play_q  <= play_q;
    end
  end

  assign sts_o.is_tick  = mode_q == MODE_TICK;
  assign sts_o.tick_go  = play_q & ~fin;
  assign sts_o.sum_ge   = sum_ge;
  assign sts_o.loop_en  = cfg_i.loop_en;
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign frame_index_o = out_frame_q;
  assign finished_o    = out_fin_q;
  assign playing_o     = out_play_q;

endmodule

`default_nettype wire

// ===== hdl/animation_frame_sequencer.sv =====
// top level of the animation frame sequencer
//
// Each input beat carries a mode (tick, play, pause, toggle, rewind) and an
// elapsed time and returns one output beat with the frame index, the finished
// flag and the playing flag. One item is worked on at a time. Non-tick modes
// and ticks that do nothing pass through the execute and done states. A tick
// goes through a multiply state, then a restoring divider that retires one bit a
// cycle: when the sum wraps in loop mode, one pass over the sum width
// for the modulo, then one pass over the frame count width for the frame
// quotient. The output register lets the next item be accepted while a
// result beat waits.
`default_nettype none

module animation_frame_sequencer
  import afs_pkg::*;
#(
  parameter int TIME_BITS       = DEF_TIME_BITS,
  parameter int SPEED_FRAC_BITS = DEF_SPEED_FRAC_BITS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [31:0]       s_axis_tdata_i,   // elapsed[31:0]
  input  wire logic [7:0]        s_axis_tuser_i,   // mode[2:0], zeros
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic      [15:0]       m_axis_tdata_o,   // frame_index[8:0], finished, playing, zeros
  input  wire logic              psel_i,
  input  wire logic              penable_i,
  input  wire logic              pwrite_i,
  input  wire logic [CFG_AW-1:0] paddr_i,
  input  wire logic [CFG_DW-1:0] pwdata_i,
  output logic      [CFG_DW-1:0] prdata_o,
  output logic                   pready_o
);

  cfg_t             cfg;
  cmd_t             cmd;
  sts_t             sts;
  logic [CNT_W-1:0] frame_index;
  logic             finished;
  logic             playing;

  afs_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .cfg_o     (cfg)
  );

  afs_ctrl #(
    .TIME_BITS       (TIME_BITS),
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  afs_dp #(
    .TIME_BITS       (TIME_BITS),
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .mode_i        (s_axis_tuser_i[MODE_W-1:0]),
    .elapsed_i     (s_axis_tdata_i[ELAPSED_W-1:0]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .frame_index_o (frame_index),
    .finished_o    (finished),
    .playing_o     (playing)
  );

  assign m_axis_tdata_o = {5'b0, playing, finished, frame_index};

endmodule

`default_nettype wire
